FILE: sv/pcfd_pkg.sv
package pcfd_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 32;
   localparam int CSR_ADDR_W          = 4;
   localparam int CSR_DATA_W          = 32;

   localparam logic [7:0]  FIRST_SYNC_RESET  = 8'hAA;
   localparam logic [7:0]  SECOND_SYNC_RESET = 8'h55;
   localparam logic [15:0] CRC_SEED_RESET    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'h1021;
   localparam int          CRC_STEPS         = 8;

   typedef enum logic [1:0] {
      REG_FIRST_SYNC  = 2'd0,
      REG_SECOND_SYNC = 2'd1,
      REG_CRC_SEED    = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      S_SYNC1,
      S_SYNC2,
      S_LENGTH,
      S_BODY,
      S_CRC,
      S_FETCH,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [7:0]  first_sync;
      logic [7:0]  second_sync;
      logic [15:0] crc_seed;
   } cfg_type;

   typedef struct packed {
      logic       start;
      logic       from_seed;
      logic [7:0] data;
   } crc_ctl_type;

endpackage

FILE: sv/pcfd_req_if.sv
interface pcfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/pcfd_rsp_if.sv
interface pcfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic [5:0] payload_count;
   logic       last_byte;

   modport source (output valid, output payload_byte, output payload_count,
                   output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input payload_count,
                   input last_byte, output ready);
endinterface

FILE: sv/preamble_crc_frame_stream_decoder.sv
// Sync, CRC and rejected length bytes are taken as they come; after an accepted length
// byte or a payload byte, S_CRC takes no request while the CRC unit folds it in, one bit per
// cycle (8 steps). After a good CRC, S_FETCH reads the store and S_EMIT sends the payload,
// a byte per cycle while ready is high; no request is taken until the last byte leaves.
// Reset (synchronous) restarts the preamble hunt and sets the sync bytes to 0xAA, 0x55
// and the CRC seed to 0xFFFF; the payload store is not cleared.
module preamble_crc_frame_stream_decoder
   import pcfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   pcfd_req_if.sink              req_chan,
   pcfd_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int POS_W  = $clog2(MAX_PAYLOAD + 2);

   cfg_type          cfg;
   crc_ctl_type      crc_ctl;
   logic [15:0]      crc_value;
   logic             crc_busy;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       crc_hi_ff, crc_hi_in;

   logic             store_we;
   logic             store_re;
   logic [POS_W-1:0] rd_pos;
   logic [POS_W-1:0] len_ext;
   logic [POS_W-1:0] len_m1;
   logic [7:0]       rd_data;
   logic             accept;
   logic [7:0]       b;

   pcfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pcfd_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .seed  (cfg.crc_seed),
      .crc   (crc_value),
      .busy  (crc_busy)
   );

   pcfd_store #(
      .DEPTH  (MAX_PAYLOAD),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (pos_ff[ADDR_W-1:0]),
      .wr_data (b),
      .rd_en   (store_re),
      .rd_addr (rd_pos[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign b       = req_chan.rx_byte;
   assign accept  = req_chan.valid && req_chan.ready;
   assign len_ext = POS_W'(len_ff);
   assign len_m1  = POS_W'(len_ext - 1'b1);
   assign rd_pos  = (state_ff == S_EMIT) ? POS_W'(pos_ff + 1'b1) : pos_ff;

   assign rsp_chan.payload_byte  = rd_data;
   assign rsp_chan.payload_count = 6'(len_ff);
   assign rsp_chan.last_byte     = (pos_ff == len_m1);

   always_comb begin
      state_in          = state_ff;
      pos_in            = pos_ff;
      len_in            = len_ff;
      crc_hi_in         = crc_hi_ff;
      req_chan.ready    = 1'b0;
      rsp_chan.valid    = 1'b0;
      crc_ctl.start     = 1'b0;
      crc_ctl.from_seed = 1'b0;
      crc_ctl.data      = b;
      store_we          = 1'b0;
      store_re          = 1'b0;
      case (state_ff)
         S_SYNC1: begin
            req_chan.ready = 1'b1;
            if (accept && b == cfg.first_sync) begin
               state_in = S_SYNC2;
            end
         end
         S_SYNC2: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               if (b == cfg.second_sync) begin
                  state_in = S_LENGTH;
               end else if (b != cfg.first_sync) begin
                  state_in = S_SYNC1;
               end
            end
         end
         S_LENGTH: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               if (b == 8'd0 || 32'(b) > 32'(MAX_PAYLOAD)) begin
                  state_in = S_SYNC1;
               end else begin
                  len_in            = LEN_W'(b);
                  pos_in            = '0;
                  crc_ctl.start     = 1'b1;
                  crc_ctl.from_seed = 1'b1;
                  state_in          = S_CRC;
               end
            end
         end
         S_BODY: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               if (pos_ff < len_ext) begin
                  store_we      = 1'b1;
                  crc_ctl.start = 1'b1;
                  pos_in        = POS_W'(pos_ff + 1'b1);
                  state_in      = S_CRC;
               end else if (pos_ff == len_ext) begin
                  crc_hi_in = b;
                  pos_in    = POS_W'(pos_ff + 1'b1);
               end else if ({crc_hi_ff, b} == crc_value) begin
                  pos_in   = '0;
                  state_in = S_FETCH;
               end else begin
                  state_in = S_SYNC1;
               end
            end
         end
         S_CRC: begin
            if (!crc_busy) begin
               state_in = S_BODY;
            end
         end
         S_FETCH: begin
            store_re = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               if (pos_ff == len_m1) begin
                  state_in = S_SYNC1;
               end else begin
                  // fetch the next byte while this one leaves
                  store_re = 1'b1;
                  pos_in   = POS_W'(pos_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = S_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_SYNC1;
         pos_ff    <= '0;
         len_ff    <= '0;
         crc_hi_ff <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         crc_hi_ff <= crc_hi_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a result is pending");

   a_crc_blocks: assert property (@(posedge clock) disable iff (reset)
      crc_busy |-> !req_chan.ready)
      else $error("request taken while the CRC unit is busy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last_byte |=> !rsp_chan.valid)
      else $error("result after the last payload byte");

   a_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (pos_ff < len_ext) && (len_ff != '0))
      else $error("store written outside the payload");

endmodule

FILE: sv/pcfd_csr.sv
module pcfd_csr
   import pcfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel = reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FIRST_SYNC:  cfg_in.first_sync  = pwdata[7:0];
            REG_SECOND_SYNC: cfg_in.second_sync = pwdata[7:0];
            REG_CRC_SEED:    cfg_in.crc_seed    = pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FIRST_SYNC:  prdata = CSR_DATA_W'(cfg_ff.first_sync);
         REG_SECOND_SYNC: prdata = CSR_DATA_W'(cfg_ff.second_sync);
         REG_CRC_SEED:    prdata = CSR_DATA_W'(cfg_ff.crc_seed);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_sync  <= FIRST_SYNC_RESET;
         cfg_ff.second_sync <= SECOND_SYNC_RESET;
         cfg_ff.crc_seed    <= CRC_SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/pcfd_crc_unit.sv
module pcfd_crc_unit
   import pcfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   input  logic [15:0] seed,
   output logic [15:0] crc,
   output logic        busy
);

   localparam int CNT_W = $clog2(CRC_STEPS);

   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [15:0]      base;
   logic [15:0]      shifted;

   assign base    = ctl.from_seed ? seed : crc_ff;
   assign shifted = crc_ff[15] ? ({crc_ff[14:0], 1'b0} ^ CRC_POLY) : {crc_ff[14:0], 1'b0};
   assign crc     = crc_ff;
   assign busy    = busy_ff;

   // one polynomial step per cycle, MSB first
   always_comb begin
      crc_in  = crc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         crc_in = shifted;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CRC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end else if (ctl.start) begin
         crc_in  = base ^ {ctl.data, 8'h00};
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      crc_ff <= crc_in;
   end

endmodule

FILE: sv/pcfd_store.sv
module pcfd_store
   import pcfd_pkg::*;
#(
   parameter int DEPTH  = MAX_PAYLOAD_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
